// ===== rtl/core/palette_pixel_skip_packer_core_macros.svh =====
// assertion macros shared by the palette skip packer core
// expects signals named clock and reset in the module that uses them
`ifndef PALETTE_PIXEL_SKIP_PACKER_CORE_MACROS_SVH
`define PALETTE_PIXEL_SKIP_PACKER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define PPSP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define PPSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ppsp_pkg.sv =====
// types and constants of the palette skip packer core
// no dependencies
`default_nettype none

package ppsp_pkg;

   localparam int PALETTE_DEPTH_DEF = 256;
   localparam int SKIP_WIDTH_DEF    = 24;
   localparam int QUEUE_DEPTH       = 4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_OFFSET      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_SKIP          = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_PIXEL   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSPARENT_INDEX = 3'd4;

   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_PIXEL = 1'b1;

   // this transparent index also makes index 0 transparent
   localparam logic [7:0] TRANSPARENT_ALL = 8'd255;

   localparam logic [23:0] START_OFFSET_RST = 24'd0;
   localparam logic [17:0] ROW_SKIP_RST     = 18'd0;
   localparam logic [2:0]  BPP_RST          = 3'd4;
   localparam logic [15:0] FRAME_WIDTH_RST  = 16'd1;
   localparam logic [7:0]  TRANSP_RST       = 8'd255;

   typedef struct packed {
      logic       action;
      logic       first_of_frame;
      logic [7:0] color_index;
      logic [7:0] load_red;
      logic [7:0] load_green;
      logic [7:0] load_blue;
   } ppsp_req_type;

   typedef struct packed {
      logic [7:0]  out_red;
      logic [7:0]  out_green;
      logic [7:0]  out_blue;
      logic [23:0] skip_bytes;
   } ppsp_rsp_type;

   // one queued operation for the palette side
   typedef struct packed {
      logic        is_load;
      logic        in_range;
      logic [7:0]  index;
      logic [23:0] rgb;
      logic [23:0] skip;
   } ppsp_entry_type;

endpackage

`default_nettype wire

// ===== rtl/core/palette_pixel_skip_packer_core.sv =====
// top level of the palette skip packer: front end, queue, palette back end
// depends on ppsp_pkg, ppsp_front, ppsp_queue, ppsp_back
//
//   port group  dir   handshake              payload
//   req_        in    req_valid/req_ready    ppsp_req_type (load or pixel)
//   rsp_        out   rsp_valid/rsp_ready    ppsp_rsp_type (opaque pixel)
//   csr_        in    csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// one item per clock while req_ready is high; skip and column update in the front end in the accept cycle
// a result passes through the queue, the palette read register and the output register
// reset clears the accumulator, column and queue and sets config to its defaults; palette stays unwritten
// a stalled rsp_ fills the output, lookup stage and 4-deep queue before req_ready drops
// loads drain from the queue even while the output is stalled
`default_nettype none

module palette_pixel_skip_packer_core
   import ppsp_pkg::*;
#(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
   parameter int SKIP_WIDTH    = SKIP_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire ppsp_req_type           req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output ppsp_rsp_type                rsp_data
);

   logic           push_valid, push_ready, pop_valid, pop_ready;
   ppsp_entry_type push_data, pop_data;

   ppsp_front #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .SKIP_WIDTH    (SKIP_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ppsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ppsp_back #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/core/ppsp_queue.sv =====
// short fifo between the classifier and the palette side
// depends on ppsp_pkg for the entry type
`default_nettype none

module ppsp_queue
   import ppsp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push_valid,
   output logic                push_ready,
   input  wire ppsp_entry_type push_data,
   output logic                pop_valid,
   input  wire logic           pop_ready,
   output ppsp_entry_type      pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   ppsp_entry_type   slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`include "palette_pixel_skip_packer_core_macros.svh"

   `PPSP_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_FULL, "queue count above depth")
   `PPSP_ASSERT_NEXT(a_count_up, push && !pop, count_ff == $past(count_ff) + 1'b1, "count missed a push")
   `PPSP_ASSERT_NEXT(a_count_down, pop && !push, count_ff == $past(count_ff) - 1'b1, "count missed a pop")
   `PPSP_ASSERT_IMP(a_ptr_match, count_ff == '0 || count_ff == CNT_FULL, wr_ptr_ff == rd_ptr_ff, "pointers out of step")

endmodule

`default_nettype wire

// ===== rtl/core/ppsp_front.sv =====
// front end: config registers, row and skip tracking, transparency check
// depends on ppsp_pkg; pushes loads and opaque pixels into the queue
`default_nettype none

module ppsp_front
   import ppsp_pkg::*;
#(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
   parameter int SKIP_WIDTH    = SKIP_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire ppsp_req_type           req_data,
   output logic                        push_valid,
   input  wire logic                   push_ready,
   output ppsp_entry_type              push_data
);

   localparam int SUM_W = ((SKIP_WIDTH > 24) ? SKIP_WIDTH : 24) + 1;
   localparam logic [SUM_W-1:0] SKIP_MAX = {{(SUM_W - SKIP_WIDTH){1'b0}}, {SKIP_WIDTH{1'b1}}};
   localparam logic [SUM_W-1:0] OUT_MAX  = {{(SUM_W - 24){1'b0}}, {24{1'b1}}};
   localparam logic [8:0]       DEPTH_LIM = 9'(PALETTE_DEPTH);

   logic [23:0] start_offset_ff, start_offset_in;
   logic [17:0] row_skip_ff, row_skip_in;
   logic [2:0]  bpp_ff, bpp_in;
   logic [15:0] frame_width_ff, frame_width_in;
   logic [7:0]  transp_ff, transp_in;

   logic [15:0]           column_ff, column_in;
   logic [SKIP_WIDTH-1:0] acc_ff, acc_in;

   logic                  accept, is_pixel, transparent, new_row;
   logic [15:0]           col_base;
   logic [SUM_W-1:0]      start_ext, start_sat, row_sum, row_sat, base, bpp_sum, bpp_sat;

   assign csr_ready = 1'b1;

   always_comb begin
      start_offset_in = start_offset_ff;
      row_skip_in     = row_skip_ff;
      bpp_in          = bpp_ff;
      frame_width_in  = frame_width_ff;
      transp_in       = transp_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_OFFSET:      start_offset_in = csr_data;
            CSR_ROW_SKIP:          row_skip_in     = csr_data[17:0];
            CSR_BYTES_PER_PIXEL:   bpp_in          = csr_data[2:0];
            CSR_FRAME_WIDTH:       frame_width_in  = csr_data[15:0];
            CSR_TRANSPARENT_INDEX: transp_in       = csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign is_pixel  = (req_data.action == ACTION_PIXEL);

   assign transparent = (req_data.color_index == transp_ff) ||
                        (req_data.color_index == 8'd0 && transp_ff == TRANSPARENT_ALL);

   // a zero width starts a new row on every pixel
   assign new_row   = !req_data.first_of_frame && (column_ff >= frame_width_ff);

   always_comb begin
      start_ext = SUM_W'(start_offset_ff);
      start_sat = (start_ext > SKIP_MAX) ? SKIP_MAX : start_ext;
      row_sum   = SUM_W'(acc_ff) + SUM_W'(row_skip_ff);
      row_sat   = (row_sum > SKIP_MAX) ? SKIP_MAX : row_sum;
      if (req_data.first_of_frame) begin
         base = start_sat;
      end else if (new_row) begin
         base = row_sat;
      end else begin
         base = SUM_W'(acc_ff);
      end
      bpp_sum = base + SUM_W'(bpp_ff);
      bpp_sat = (bpp_sum > SKIP_MAX) ? SKIP_MAX : bpp_sum;
      col_base = (req_data.first_of_frame || new_row) ? 16'd0 : column_ff;
   end

   always_comb begin
      column_in = column_ff;
      acc_in    = acc_ff;
      if (accept && is_pixel) begin
         column_in = (col_base != 16'hFFFF) ? col_base + 16'd1 : col_base;
         acc_in    = transparent ? bpp_sat[SKIP_WIDTH-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_offset_ff <= START_OFFSET_RST;
         row_skip_ff     <= ROW_SKIP_RST;
         bpp_ff          <= BPP_RST;
         frame_width_ff  <= FRAME_WIDTH_RST;
         transp_ff       <= TRANSP_RST;
         column_ff       <= '0;
         acc_ff          <= '0;
      end else begin
         start_offset_ff <= start_offset_in;
         row_skip_ff     <= row_skip_in;
         bpp_ff          <= bpp_in;
         frame_width_ff  <= frame_width_in;
         transp_ff       <= transp_in;
         column_ff       <= column_in;
         acc_ff          <= acc_in;
      end
   end

   // transparent pixels only feed the accumulator
   assign push_valid         = req_valid && (!is_pixel || !transparent);
   assign push_data.is_load  = !is_pixel;
   assign push_data.in_range = ({1'b0, req_data.color_index} < DEPTH_LIM);
   assign push_data.index    = req_data.color_index;
   assign push_data.rgb      = {req_data.load_red, req_data.load_green, req_data.load_blue};
   assign push_data.skip     = (base > OUT_MAX) ? 24'hFFFFFF : base[23:0];

endmodule

`default_nettype wire

// ===== rtl/core/ppsp_back.sv =====
// back end: palette memory, registered lookup and output register
// depends on ppsp_pkg; drains the queue filled by the front end
`default_nettype none

module ppsp_back
   import ppsp_pkg::*;
#(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           pop_valid,
   output logic                pop_ready,
   input  wire ppsp_entry_type pop_data,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output ppsp_rsp_type        rsp_data
);

   localparam int IDX_W = $clog2(PALETTE_DEPTH);

   logic [23:0]      palette_ff [PALETTE_DEPTH];
   logic [23:0]      rd_data_ff;
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_in_range_ff;
   logic [23:0]      s1_skip_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   ppsp_rsp_type     rsp_data_ff;
   logic             out_adv, s1_adv, pop, rd_en, wr_en;
   logic [IDX_W-1:0] addr;

   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = !s1_valid_ff || out_adv;
   // loads never wait on the output side
   assign pop_ready = pop_data.is_load || s1_adv;
   assign pop       = pop_valid && pop_ready;
   assign rd_en     = pop && !pop_data.is_load;
   assign wr_en     = pop && pop_data.is_load && pop_data.in_range;
   assign addr      = pop_data.index[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         palette_ff[addr] <= pop_data.rgb;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff     <= palette_ff[addr];
         s1_in_range_ff <= pop_data.in_range;
         s1_skip_ff     <= pop_data.skip;
      end
   end

   always_comb begin
      s1_valid_in  = s1_adv ? rd_en : s1_valid_ff;
      rsp_valid_in = out_adv ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && s1_valid_ff) begin
         {rsp_data_ff.out_red, rsp_data_ff.out_green, rsp_data_ff.out_blue} <=
            s1_in_range_ff ? rd_data_ff : 24'd0;
         rsp_data_ff.skip_bytes <= s1_skip_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "palette_pixel_skip_packer_core_macros.svh"

   `PPSP_ASSERT_NEXT(a_read_lands, rd_en, s1_valid_ff, "lookup lost after read")
   `PPSP_ASSERT_NEXT(a_s1_holds, s1_valid_ff && !out_adv, s1_valid_ff && $stable(s1_skip_ff), "lookup stage dropped while stalled")
   `PPSP_ASSERT_IMP(a_rsp_source, $rose(rsp_valid_ff), $past(s1_valid_ff), "result without lookup")
   `PPSP_ASSERT_IMP(a_no_read_stalled, rd_en, s1_adv, "read while lookup stage blocked")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking bench for palette_pixel_skip_packer_core: palette loads, pixel words, csr settings
// depends on ppsp_pkg and the core rtl; a scoreboard class predicts every opaque pixel word
`default_nettype none

module tb_top;
   import ppsp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int          PHASE_WORDS = 175;
   localparam int          PHASES      = 10;

   // tracks palette, column, skip and settings; holds pixel words still owed by the core
   class packer_scoreboard;
      logic [23:0]  palette_rgb [256];
      logic [15:0]  column;
      logic [23:0]  skip_acc;
      logic [23:0]  start_offset;
      logic [17:0]  row_skip;
      logic [2:0]   pixel_bytes;
      logic [15:0]  frame_width;
      logic [7:0]   clear_index;
      ppsp_rsp_type pending_pixels [$];
      int           errors;
      int           checked;

      function new();
         column       = '0;
         skip_acc     = '0;
         start_offset = START_OFFSET_RST;
         row_skip     = ROW_SKIP_RST;
         pixel_bytes  = BPP_RST;
         frame_width  = FRAME_WIDTH_RST;
         clear_index  = TRANSP_RST;
         errors       = 0;
         checked      = 0;
      endfunction

      function logic [23:0] add_capped(logic [23:0] a, logic [23:0] b);
         logic [24:0] sum;
         sum = {1'b0, a} + {1'b0, b};
         return sum[24] ? 24'hFFFFFF : sum[23:0];
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_START_OFFSET:      start_offset = data[23:0];
            CSR_ROW_SKIP:          row_skip     = data[17:0];
            CSR_BYTES_PER_PIXEL:   pixel_bytes  = data[2:0];
            CSR_FRAME_WIDTH:       frame_width  = data[15:0];
            CSR_TRANSPARENT_INDEX: clear_index  = data[7:0];
            default: ;
         endcase
      endfunction

      function void note_req_word(ppsp_req_type w);
         ppsp_rsp_type px;
         if (w.action == ACTION_LOAD) begin
            palette_rgb[w.color_index] = {w.load_red, w.load_green, w.load_blue};
            return;
         end
         if (w.first_of_frame) begin
            skip_acc = start_offset;
            column   = '0;
         end else if (column >= frame_width) begin
            skip_acc = add_capped(skip_acc, 24'(row_skip));
            column   = '0;
         end
         if (column != 16'hFFFF) column = column + 16'd1;
         if (w.color_index == clear_index ||
             (w.color_index == 8'd0 && clear_index == TRANSPARENT_ALL)) begin
            skip_acc = add_capped(skip_acc, 24'(pixel_bytes));
            return;
         end
         {px.out_red, px.out_green, px.out_blue} = palette_rgb[w.color_index];
         px.skip_bytes = skip_acc;
         pending_pixels.push_back(px);
         skip_acc = '0;
      endfunction

      task report(string what, logic [23:0] want, logic [23:0] got);
         $display("mismatch on %s: expected %06h, got %06h", what, want, got);
         errors++;
      endtask

      task check_rsp_word(ppsp_rsp_type got);
         ppsp_rsp_type want;
         checked++;
         if (pending_pixels.size() == 0) begin
            report("word with nothing pending (skip)", '0, got.skip_bytes);
            return;
         end
         want = pending_pixels.pop_front();
         if (got.out_red !== want.out_red) report("out_red", 24'(want.out_red), 24'(got.out_red));
         if (got.out_green !== want.out_green)
            report("out_green", 24'(want.out_green), 24'(got.out_green));
         if (got.out_blue !== want.out_blue)
            report("out_blue", 24'(want.out_blue), 24'(got.out_blue));
         if (got.skip_bytes !== want.skip_bytes)
            report("skip_bytes", want.skip_bytes, got.skip_bytes);
      endtask
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   ppsp_req_type           req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   ppsp_rsp_type           rsp_data;

   packer_scoreboard sb;
   int unsigned      cycle_count = 0;
   int               words_sent  = 0;
   int               csr_writes  = 0;
   int               hold_left   = 0;
   bit               req_calm    = 1'b0;
   bit               rsp_calm    = 1'b0;
   bit               loaded [256];
   logic [7:0]       cur_clear   = TRANSP_RST;
   logic [15:0]      cur_width   = FRAME_WIDTH_RST;
   int               clear_pct   = 30;

   palette_pixel_skip_packer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still pending", cycle_count,
                  sb.pending_pixels.size());
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // sampled values before the edge updates land
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_register(csr_index, csr_data);
         if (req_valid && req_ready) sb.note_req_word(req_data);
         if (rsp_valid && rsp_ready) sb.check_rsp_word(rsp_data);
      end
   end

   // receiver: random stalls, plus long hold-offs counted down here
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= rsp_calm || ($urandom_range(99) >= 13);
         end
      end
   end

   task automatic send_word(ppsp_req_type w);
      if (!req_calm && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 13);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_load(logic [7:0] idx, logic [23:0] rgb, logic first);
      ppsp_req_type w;
      w.action         = ACTION_LOAD;
      w.first_of_frame = first;
      w.color_index    = idx;
      {w.load_red, w.load_green, w.load_blue} = rgb;
      loaded[idx] = 1'b1;
      send_word(w);
   endtask

   task automatic send_pixel_at(logic first, logic [7:0] idx);
      ppsp_req_type w;
      w.action         = ACTION_PIXEL;
      w.first_of_frame = first;
      w.color_index    = idx;
      {w.load_red, w.load_green, w.load_blue} = 24'($urandom);
      send_word(w);
   endtask

   // picks a clear or opaque index; an opaque entry is loaded before its first read
   task automatic send_pixel(logic first);
      logic [7:0] idx;
      bit         clear;
      if ($urandom_range(99) < clear_pct)
         idx = (cur_clear == TRANSPARENT_ALL && $urandom_range(1) == 1) ? 8'd0 : cur_clear;
      else
         idx = 8'($urandom_range(255));
      clear = (idx == cur_clear) || (idx == 8'd0 && cur_clear == TRANSPARENT_ALL);
      if (!clear && !loaded[idx]) send_load(idx, 24'($urandom), 1'($urandom));
      send_pixel_at(first, idx);
   endtask

   // mostly whole rows; a few stray frame starts and palette rewrites in between
   task automatic send_frame();
      int npix;
      bit first;
      if (cur_width != 0 && cur_width <= 12)
         npix = int'(cur_width) * $urandom_range(1, 4);
      else
         npix = $urandom_range(1, 24);
      for (int p = 0; p < npix; p++) begin
         if ($urandom_range(99) < 8) send_load(8'($urandom), 24'($urandom), 1'($urandom));
         first = (p == 0) ? ($urandom_range(99) < 92) : ($urandom_range(99) < 3);
         send_pixel(first);
      end
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_writes++;
   endtask

   // waits for the core to drain, then writes all registers; junk above each field but the start offset
   task automatic apply_setting(logic [23:0] start, logic [17:0] rs, logic [2:0] bpp,
                                logic [15:0] fw, logic [7:0] clr);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      write_register(CSR_START_OFFSET, start);
      write_register(CSR_ROW_SKIP, (24'($urandom) << 18) | 24'(rs));
      write_register(CSR_BYTES_PER_PIXEL, (24'($urandom) << 3) | 24'(bpp));
      write_register(CSR_FRAME_WIDTH, (24'($urandom) << 16) | 24'(fw));
      write_register(CSR_TRANSPARENT_INDEX, (24'($urandom) << 8) | 24'(clr));
      // unused indexes must be ignored
      write_register(CSR_TRANSPARENT_INDEX + 3'($urandom_range(1, 3)), 24'($urandom));
      csr_valid <= 1'b0;
      cur_width = fw;
      cur_clear = clr;
   endtask

   initial begin
      int goal;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: 255 and 0 both clear, four bytes per pixel, one pixel per row
      send_load(8'd0, 24'h000000, 1'b1);
      send_load(8'd255, 24'hFFFFFF, 1'b0);
      send_load(8'd1, 24'hA55AC3, 1'b0);
      send_load(8'd128, 24'h5AA53C, 1'b0);
      send_pixel_at(1'b0, 8'd0);     // before any frame start
      send_pixel_at(1'b0, 8'd255);
      send_pixel_at(1'b0, 8'd1);
      send_pixel_at(1'b1, 8'd128);
      send_pixel_at(1'b0, 8'd1);
      // full offsets saturate; zero width makes every pixel a new row
      apply_setting(24'hFFFFFF, 18'h3FFFF, 3'd7, 16'd0, 8'd0);
      send_pixel_at(1'b1, 8'd0);
      send_pixel_at(1'b0, 8'd0);
      send_pixel_at(1'b0, 8'd255);
      send_pixel_at(1'b0, 8'd1);
      send_pixel_at(1'b0, 8'd128);
      apply_setting(24'd5, 18'd1, 3'd0, 16'd65535, 8'd128);
      send_pixel_at(1'b1, 8'd128);
      send_pixel_at(1'b0, 8'd0);
      send_pixel_at(1'b0, 8'd255);
      send_pixel_at(1'b0, 8'd128);
      send_pixel_at(1'b0, 8'd1);

      for (int k = 0; k < PHASES; k++) begin
         case (k)
            0: apply_setting(24'd0, 18'd0, 3'd1, 16'd4, 8'd255);
            1: apply_setting(24'hFFFFFF, 18'h3FFFF, 3'd2, 16'd1, 8'd0);
            2: apply_setting(24'($urandom), 18'($urandom), 3'd3, 16'd0, 8'($urandom));
            3: apply_setting(24'd100, 18'h3FFFF, 3'd4, 16'd65535, 8'd255);
            4: apply_setting(24'($urandom_range(0, 999)), 18'd10, 3'd5, 16'd3, 8'd17);
            5: apply_setting(24'hFFFFFF, 18'd0, 3'd6, 16'd7, 8'($urandom));
            6: apply_setting(24'd0, 18'h3FFFF, 3'd7, 16'd1, 8'd255);
            7: apply_setting(24'($urandom), 18'($urandom), 3'd0, 16'($urandom_range(2, 12)),
                             8'd128);
            8: apply_setting(24'($urandom), 18'($urandom), 3'd1, 16'd5, 8'($urandom));
            default: apply_setting(24'd0, 18'd0, 3'd4, 16'd1, 8'd255);
         endcase
         clear_pct = (k == 5) ? 90 : (k == 6) ? 95 : (k == 8) ? 20 : 30;
         req_calm  = (k == 2 || k == 4 || k == 7);
         rsp_calm  = (k == 4);
         // hold the output off long enough for the core to back up into req_ready
         if (k == 2 || k == 7) hold_left = 250;
         goal = words_sent + PHASE_WORDS;
         while (words_sent < goal) send_frame();
      end

      req_valid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d words under %0d csr writes, %0d pixel words checked",
               words_sent, csr_writes, sb.checked);
      $display("settings spanned zero and full widths, offsets, saturation, pixel sizes 0-7");
      if (sb.errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
